[rtl/bblru_pkg.sv]
// bblru_pkg: shared types, codes and defaults for the block-buffer LRU tag table.
// No dependencies; imported by every module under rtl except bblru_ram.
package bblru_pkg;

    localparam int SLOTS_DEF      = 16;
    localparam int STAMP_BITS_DEF = 16;
    localparam int BLOCK_W        = 16;
    localparam int DEVICE_W       = 16;

    localparam logic [1:0] FN_GET           = 2'd0;
    localparam logic [1:0] FN_RELEASE       = 2'd1;
    localparam logic [1:0] FN_RELEASE_DIRTY = 2'd2;
    localparam logic [1:0] FN_IO_DONE       = 2'd3;

    localparam logic [2:0] ST_HIT      = 3'd0;
    localparam logic [2:0] ST_ALLOC    = 3'd1;
    localparam logic [2:0] ST_WAIT     = 3'd2;
    localparam logic [2:0] ST_NOFREE   = 3'd3;
    localparam logic [2:0] ST_VICTIM   = 3'd4;
    localparam logic [2:0] ST_RELEASED = 3'd5;
    localparam logic [2:0] ST_IGNORED  = 3'd6;

    typedef struct packed {
        logic [1:0]          func;
        logic [3:0]          slot;
        logic [BLOCK_W-1:0]  block_number;
        logic [DEVICE_W-1:0] device;
        logic                io_error;
        logic                synchronous;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] result_slot;
        logic       data_valid;
        logic       woke_waiter;
    } rsp_t;

    typedef struct packed {
        logic capture;
        logic scan;
        logic get_finish;
        logic rel_finish;
    } cmd_t;

    typedef struct packed {
        logic req_is_get;
        logic scan_done;
        logic out_free;
    } sts_t;

endpackage

[rtl/bblru_ram.sv]
// bblru_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module bblru_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/bblru_ctrl.sv]
// bblru_ctrl: request sequencer for the tag table (idle, scan, finish).
// Depends on bblru_pkg for the command and status structs.
module bblru_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  bblru_pkg::sts_t  sts,
    output bblru_pkg::cmd_t  cmd
);
    import bblru_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE     = 4'b0001,
        S_SCAN     = 4'b0010,
        S_GET_DONE = 4'b0100,
        S_REL      = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = sts.req_is_get ? S_SCAN : S_REL;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_GET_DONE;
                end
            end
            S_GET_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.get_finish = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_REL:
            begin
                if (sts.out_free)
                begin
                    cmd.rel_finish = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);

endmodule

[rtl/bblru_dp.sv]
// bblru_dp: slot flags, tag and stamp stores, sequential slot scan, result register.
// Depends on bblru_pkg and bblru_ram.
module bblru_dp #(
    parameter int SLOTS      = bblru_pkg::SLOTS_DEF,
    parameter int STAMP_BITS = bblru_pkg::STAMP_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  bblru_pkg::req_t  req,
    input  bblru_pkg::cmd_t  cmd,
    output bblru_pkg::sts_t  sts,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output bblru_pkg::rsp_t  rsp
);
    import bblru_pkg::*;

    localparam int SIDX_W = $clog2(SLOTS);
    localparam int TAG_W  = BLOCK_W + DEVICE_W;
    localparam logic [SIDX_W-1:0] LAST_IDX = SIDX_W'(SLOTS - 1);

    req_t                  req_reg;
    logic [SLOTS-1:0]      busy_reg, busy_next;
    logic [SLOTS-1:0]      waiter_reg, waiter_next;
    logic [SLOTS-1:0]      valid_reg, valid_next;
    logic [SLOTS-1:0]      dirty_reg, dirty_next;
    logic [SLOTS-1:0]      error_reg, error_next;
    logic [SLOTS-1:0]      tag_vld_reg, tag_vld_next;
    logic [SLOTS-1:0]      stamp_vld_reg, stamp_vld_next;
    logic [STAMP_BITS-1:0] stamp_counter_reg, stamp_counter_next;
    logic [STAMP_BITS-1:0] counter_inc;

    logic [SIDX_W-1:0]     rd_idx_reg;
    logic [SIDX_W-1:0]     cmp_idx_reg;
    logic                  rd_active_reg;
    logic                  cmp_vld_reg;
    logic                  hit_reg;
    logic                  found_reg;
    logic [SIDX_W-1:0]     hit_idx_reg;
    logic [SIDX_W-1:0]     pick_idx_reg;
    logic [STAMP_BITS-1:0] pick_stamp_reg;

    rsp_t                  rsp_reg, rsp_next;
    logic                  rsp_valid_reg;
    logic                  load;
    logic                  out_free;

    logic                  rd_en;
    logic                  cmp_live;
    logic [TAG_W-1:0]      tag_rdata;
    logic [STAMP_BITS-1:0] stamp_rdata;
    logic [TAG_W-1:0]      cmp_tag;
    logic [STAMP_BITS-1:0] cmp_stamp;
    logic [TAG_W-1:0]      req_tag;
    logic                  hit_now;
    logic                  better_now;

    logic                  tag_we;
    logic                  stamp_we;
    logic [SIDX_W-1:0]     s_idx;
    logic                  in_range;
    logic                  do_rel;

    // tag and stamp stores; per-slot valid bits make unwritten entries read as zero
    bblru_ram #(.WIDTH(TAG_W), .DEPTH(SLOTS)) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (pick_idx_reg),
        .wdata (req_tag),
        .re    (rd_en),
        .raddr (rd_idx_reg),
        .rdata (tag_rdata)
    );

    bblru_ram #(.WIDTH(STAMP_BITS), .DEPTH(SLOTS)) u_stamp_ram (
        .clk   (clk),
        .we    (stamp_we),
        .waddr (s_idx),
        .wdata (counter_inc),
        .re    (rd_en),
        .raddr (rd_idx_reg),
        .rdata (stamp_rdata)
    );

    assign req_tag     = {req_reg.block_number, req_reg.device};
    assign rd_en       = cmd.scan && rd_active_reg;
    assign cmp_live    = cmd.scan && cmp_vld_reg;
    assign cmp_tag     = tag_vld_reg[cmp_idx_reg] ? tag_rdata : '0;
    assign cmp_stamp   = stamp_vld_reg[cmp_idx_reg] ? stamp_rdata : '0;
    assign hit_now     = cmp_live && (cmp_tag == req_tag);
    assign better_now  = cmp_live && !hit_now && !busy_reg[cmp_idx_reg]
                         && (!found_reg || (cmp_stamp < pick_stamp_reg));

    assign s_idx       = SIDX_W'(req_reg.slot);
    assign in_range    = 32'(req_reg.slot) < 32'(SLOTS);
    assign do_rel      = (req_reg.func != FN_IO_DONE) || !req_reg.synchronous;
    assign counter_inc = stamp_counter_reg + STAMP_BITS'(1);

    assign out_free       = !rsp_valid_reg || !rsp_stall;
    assign sts.req_is_get = (req.func == FN_GET);
    assign sts.scan_done  = cmp_live && (hit_now || (cmp_idx_reg == LAST_IDX));
    assign sts.out_free   = out_free;

    always_comb
    begin
        busy_next          = busy_reg;
        waiter_next        = waiter_reg;
        valid_next         = valid_reg;
        dirty_next         = dirty_reg;
        error_next         = error_reg;
        tag_vld_next       = tag_vld_reg;
        stamp_vld_next     = stamp_vld_reg;
        stamp_counter_next = stamp_counter_reg;
        rsp_next           = rsp_reg;
        load               = 1'b0;
        tag_we             = 1'b0;
        stamp_we           = 1'b0;

        if (cmd.get_finish)
        begin
            load                 = 1'b1;
            rsp_next.woke_waiter = 1'b0;
            if (hit_reg)
            begin
                rsp_next.result_slot = 4'(hit_idx_reg);
                rsp_next.data_valid  = valid_reg[hit_idx_reg] && !error_reg[hit_idx_reg];
                if (busy_reg[hit_idx_reg])
                begin
                    waiter_next[hit_idx_reg] = 1'b1;
                    rsp_next.status          = ST_WAIT;
                end
                else
                begin
                    busy_next[hit_idx_reg] = 1'b1;
                    rsp_next.status        = ST_HIT;
                end
            end
            else if (found_reg)
            begin
                busy_next[pick_idx_reg] = 1'b1;
                rsp_next.result_slot    = 4'(pick_idx_reg);
                if (dirty_reg[pick_idx_reg])
                begin
                    rsp_next.status     = ST_VICTIM;
                    rsp_next.data_valid = valid_reg[pick_idx_reg] && !error_reg[pick_idx_reg];
                end
                else
                begin
                    tag_we                     = 1'b1;
                    tag_vld_next[pick_idx_reg] = 1'b1;
                    valid_next[pick_idx_reg]   = 1'b0;
                    rsp_next.status            = ST_ALLOC;
                    rsp_next.data_valid        = 1'b0;
                end
            end
            else
            begin
                rsp_next.status      = ST_NOFREE;
                rsp_next.result_slot = '0;
                rsp_next.data_valid  = 1'b0;
            end
        end

        if (cmd.rel_finish)
        begin
            load                 = 1'b1;
            rsp_next.status      = ST_IGNORED;
            rsp_next.result_slot = req_reg.slot;
            rsp_next.data_valid  = 1'b0;
            rsp_next.woke_waiter = 1'b0;
            if (in_range)
            begin
                case (req_reg.func)
                    FN_RELEASE_DIRTY:
                    begin
                        dirty_next[s_idx] = 1'b1;
                        valid_next[s_idx] = 1'b1;
                    end
                    FN_IO_DONE:
                    begin
                        valid_next[s_idx] = 1'b1;
                        dirty_next[s_idx] = 1'b0;
                        error_next[s_idx] = req_reg.io_error;
                    end
                    default:
                    begin
                    end
                endcase
                if (do_rel && busy_reg[s_idx])
                begin
                    rsp_next.woke_waiter = waiter_reg[s_idx];
                    rsp_next.status      = ST_RELEASED;
                    busy_next[s_idx]     = 1'b0;
                    waiter_next[s_idx]   = 1'b0;
                    stamp_counter_next   = counter_inc;
                    // counter wrapped: every stamp reads as zero again
                    if (counter_inc == '0)
                    begin
                        stamp_vld_next = '0;
                    end
                    stamp_vld_next[s_idx] = 1'b1;
                    stamp_we              = 1'b1;
                end
                rsp_next.data_valid = valid_next[s_idx] && !error_next[s_idx];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg          <= '0;
            waiter_reg        <= '0;
            valid_reg         <= '0;
            dirty_reg         <= '0;
            error_reg         <= '0;
            tag_vld_reg       <= '0;
            stamp_vld_reg     <= '0;
            stamp_counter_reg <= '0;
            rd_idx_reg        <= '0;
            rd_active_reg     <= 1'b0;
            cmp_vld_reg       <= 1'b0;
            hit_reg           <= 1'b0;
            found_reg         <= 1'b0;
            rsp_valid_reg     <= 1'b0;
        end
        else
        begin
            busy_reg          <= busy_next;
            waiter_reg        <= waiter_next;
            valid_reg         <= valid_next;
            dirty_reg         <= dirty_next;
            error_reg         <= error_next;
            tag_vld_reg       <= tag_vld_next;
            stamp_vld_reg     <= stamp_vld_next;
            stamp_counter_reg <= stamp_counter_next;

            if (cmd.capture)
            begin
                rd_idx_reg    <= '0;
                rd_active_reg <= 1'b1;
                cmp_vld_reg   <= 1'b0;
                hit_reg       <= 1'b0;
                found_reg     <= 1'b0;
            end
            else
            begin
                cmp_vld_reg <= rd_en;
                if (rd_en)
                begin
                    if (rd_idx_reg == LAST_IDX)
                    begin
                        rd_active_reg <= 1'b0;
                    end
                    else
                    begin
                        rd_idx_reg <= rd_idx_reg + SIDX_W'(1);
                    end
                end
                if (hit_now)
                begin
                    hit_reg <= 1'b1;
                end
                if (better_now)
                begin
                    found_reg <= 1'b1;
                end
            end

            if (load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req;
        end
        if (rd_en)
        begin
            cmp_idx_reg <= rd_idx_reg;
        end
        if (hit_now)
        begin
            hit_idx_reg <= cmp_idx_reg;
        end
        if (better_now)
        begin
            pick_idx_reg   <= cmp_idx_reg;
            pick_stamp_reg <= cmp_stamp;
        end
        if (load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_cmp_follows_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_vld_reg |-> $past(cmd.scan))
        else $error("compare stage valid without a read issued");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.get_finish || cmd.rel_finish) |-> out_free)
        else $error("result loaded over a word not yet taken");

    a_counter_only_on_release: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.rel_finish |=> $stable(stamp_counter_reg))
        else $error("stamp counter moved outside a release");

    a_busy_only_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.get_finish || cmd.rel_finish) |=> $stable(busy_reg))
        else $error("busy flags changed outside a finish step");

endmodule

[rtl/block_buffer_cache_lru_core.sv]
// Block-buffer LRU tag table: get scans the slots one per cycle through the tag and
// stamp RAM read ports, stopping early on a hit; release, release dirty and io done
// skip the scan. A new request is accepted only after the previous one has finished.
// The result sits in an output register; a new word is accepted while it waits.
// Reset (rst_n low, asynchronous) clears all flags, the stamp counter and the per-slot
// valid bits, so every tag and stamp reads as zero at once; no clearing pass.
module block_buffer_cache_lru_core #(
    parameter int SLOTS      = bblru_pkg::SLOTS_DEF,
    parameter int STAMP_BITS = bblru_pkg::STAMP_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  bblru_pkg::req_t  req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output bblru_pkg::rsp_t  rsp
);
    import bblru_pkg::*;

    cmd_t cmd;
    sts_t sts;

    bblru_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    bblru_dp #(
        .SLOTS      (SLOTS),
        .STAMP_BITS (STAMP_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

[sim/tb_top.sv]
// tb_top: self-checking testbench for block_buffer_cache_lru_core (LRU block-buffer tag table).
// Depends on rtl/bblru_pkg.sv and rtl/block_buffer_cache_lru_core.sv; a class tracks
// the expected tag table and checks every response word.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bblru_pkg::*;

    localparam int SLOT_N       = SLOTS_DEF;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HIT_PAIRS    = 16;
    localparam int RANDOM_WORDS = 1000;

    class lru_table_tracker;
        bit [BLOCK_W-1:0]        blk_tag [SLOT_N];
        bit [DEVICE_W-1:0]       dev_tag [SLOT_N];
        bit                      busy    [SLOT_N];
        bit                      waiter  [SLOT_N];
        bit                      valid   [SLOT_N];
        bit                      dirty   [SLOT_N];
        bit                      failed  [SLOT_N];
        bit [STAMP_BITS_DEF-1:0] stamp   [SLOT_N];
        bit [STAMP_BITS_DEF-1:0] stamp_ctr;
        rsp_t                    pending_rsp[$];
        int                      mismatches;
        int                      words_checked;

        function bit fresh_data(int s);
            return valid[s] && !failed[s];
        endfunction

        function int busy_count();
            int n;
            n = 0;
            foreach (busy[i]) n += busy[i];
            return n;
        endfunction

        function rsp_t unlock_slot(int s);
            rsp_t r;
            r = '0;
            r.result_slot = s[3:0];
            if (!busy[s]) begin
                r.status = ST_IGNORED;
                r.data_valid = fresh_data(s);
                return r;
            end
            r.woke_waiter = waiter[s];
            busy[s] = 1'b0;
            waiter[s] = 1'b0;
            stamp_ctr = stamp_ctr + 1'b1;
            if (stamp_ctr == 0)
                foreach (stamp[i]) stamp[i] = '0;
            stamp[s] = stamp_ctr;
            r.status = ST_RELEASED;
            r.data_valid = fresh_data(s);
            return r;
        endfunction

        function rsp_t lookup_block(bit [BLOCK_W-1:0] blk, bit [DEVICE_W-1:0] dev);
            rsp_t r;
            bit   found;
            int   pick;
            r = '0;
            found = 1'b0;
            pick = 0;
            for (int i = 0; i < SLOT_N; i++) begin
                if (blk_tag[i] == blk && dev_tag[i] == dev) begin
                    r.result_slot = i[3:0];
                    r.data_valid = fresh_data(i);
                    if (busy[i]) begin
                        waiter[i] = 1'b1;
                        r.status = ST_WAIT;
                    end
                    else begin
                        busy[i] = 1'b1;
                        r.status = ST_HIT;
                    end
                    return r;
                end
                if (!busy[i] && (!found || stamp[i] < stamp[pick])) begin
                    pick = i;
                    found = 1'b1;
                end
            end
            if (!found) begin
                r.status = ST_NOFREE;
                return r;
            end
            busy[pick] = 1'b1;
            r.result_slot = pick[3:0];
            if (dirty[pick]) begin
                r.status = ST_VICTIM;
                r.data_valid = fresh_data(pick);
                return r;
            end
            blk_tag[pick] = blk;
            dev_tag[pick] = dev;
            valid[pick] = 1'b0;
            r.status = ST_ALLOC;
            return r;
        endfunction

        function void note_request(req_t w);
            rsp_t r;
            int   s;
            s = w.slot;
            case (w.func)
                FN_GET:     r = lookup_block(w.block_number, w.device);
                FN_RELEASE: r = unlock_slot(s);
                FN_RELEASE_DIRTY:
                begin
                    dirty[s] = 1'b1;
                    valid[s] = 1'b1;
                    r = unlock_slot(s);
                end
                default:
                begin
                    valid[s] = 1'b1;
                    dirty[s] = 1'b0;
                    failed[s] = w.io_error;
                    if (w.synchronous) begin
                        r = '0;
                        r.status = ST_IGNORED;
                        r.result_slot = w.slot;
                        r.data_valid = fresh_data(s);
                    end
                    else begin
                        r = unlock_slot(s);
                    end
                end
            endcase
            pending_rsp.push_back(r);
        endfunction

        task report_mismatch(string field, logic [15:0] got, logic [15:0] want);
            $display("mismatch on %s: got %0h expected %0h (response word %0d)",
                     field, got, want, words_checked);
            mismatches++;
        endtask

        task check_response(rsp_t got);
            rsp_t want;
            words_checked++;
            if (pending_rsp.size() == 0) begin
                report_mismatch("unexpected word", 16'(got), 16'h0000);
                return;
            end
            want = pending_rsp.pop_front();
            if (got.status !== want.status)
                report_mismatch("status", 16'(got.status), 16'(want.status));
            if (got.result_slot !== want.result_slot)
                report_mismatch("result_slot", 16'(got.result_slot),
                                16'(want.result_slot));
            if (got.data_valid !== want.data_valid)
                report_mismatch("data_valid", 16'(got.data_valid), 16'(want.data_valid));
            if (got.woke_waiter !== want.woke_waiter)
                report_mismatch("woke_waiter", 16'(got.woke_waiter),
                                16'(want.woke_waiter));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    lru_table_tracker tracker;
    bit idle_on;
    int cycle_count;

    block_buffer_cache_lru_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #4ns clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // response side: check accepted words, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            tracker.check_response(rsp);
        rsp_stall <= idle_on && ($urandom_range(0, 99) < 32);
    end

    function automatic req_t make_word(logic [1:0] func, int slot, logic [15:0] blk,
                                       logic [15:0] dev, bit err, bit sync);
        req_t w;
        w.func = func;
        w.slot = slot[3:0];
        w.block_number = blk;
        w.device = dev;
        w.io_error = err;
        w.synchronous = sync;
        return w;
    endfunction

    // mostly get/release pairs on a small tag pool, some noise words
    function automatic req_t random_word();
        req_t w;
        int   pick;
        int   busy_n;
        int   s;
        w.func = FN_GET;
        w.slot = 4'($urandom_range(0, 15));
        w.block_number = 16'($urandom);
        w.device = 16'($urandom);
        w.io_error = 1'($urandom_range(0, 1));
        w.synchronous = 1'($urandom_range(0, 1));
        busy_n = tracker.busy_count();
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            w.func = 2'($urandom_range(0, 3));
            return w;
        end
        if (busy_n > 0 && pick < 10 + 4 * busy_n) begin
            do s = $urandom_range(0, SLOT_N - 1); while (!tracker.busy[s]);
            w.slot = s[3:0];
            w.func = 2'($urandom_range(1, 3));
            if (w.func == FN_IO_DONE)
                w.synchronous = ($urandom_range(0, 3) == 0);
            return w;
        end
        if ($urandom_range(0, 9) != 0) begin
            w.block_number = 16'($urandom_range(0, 23));
            w.device = 16'($urandom_range(0, 1));
        end
        return w;
    endfunction

    task automatic send_word(req_t w);
        while (idle_on && $urandom_range(0, 99) < 32) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req <= w;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        tracker.note_request(w);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (tracker.pending_rsp.size() != 0) @(posedge clk);
    endtask

    initial
    begin
        tracker = new();
        clk = 1'b0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_stall = 1'b0;
        idle_on = 1'b1;
        cycle_count = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset tags are all zero: block 0 device 0 hits slot 0
        send_word(make_word(FN_GET, 0, 16'h0000, 16'h0000, 1'b0, 1'b0));
        send_word(make_word(FN_GET, 0, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0));
        send_word(make_word(FN_GET, 0, 16'h0000, 16'h0000, 1'b0, 1'b0));
        send_word(make_word(FN_RELEASE, 0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
        send_word(make_word(FN_RELEASE, 0, 16'h0000, 16'h0000, 1'b0, 1'b0));
        send_word(make_word(FN_IO_DONE, 1, 16'h0000, 16'h0000, 1'b0, 1'b0));
        send_word(make_word(FN_GET, 0, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0));
        send_word(make_word(FN_RELEASE_DIRTY, 1, 16'h0000, 16'h0000, 1'b0, 1'b0));
        send_word(make_word(FN_IO_DONE, 2, 16'h0000, 16'h0000, 1'b1, 1'b1));
        send_word(make_word(FN_RELEASE_DIRTY, 15, 16'h0000, 16'h0000, 1'b0, 1'b0));
        // lock every slot (dirty ones come back as victims), then one more
        for (int i = 0; i <= SLOT_N; i++)
            send_word(make_word(FN_GET, 0, 16'h1000 + 16'(i), 16'h00A5, 1'b0, 1'b0));

        wait_drained();
        idle_on = 1'b0;
        for (int n = 0; n < RANDOM_WORDS / 2; n++) begin
            if (n == 200)
                idle_on = 1'b1;
            send_word(random_word());
        end

        // unlock everything, then back-to-back hit and release pairs on slot 0
        wait_drained();
        idle_on = 1'b0;
        for (int s = 0; s < SLOT_N; s++)
            if (tracker.busy[s])
                send_word(make_word(FN_RELEASE, s, 16'h0000, 16'h0000, 1'b0, 1'b0));
        for (int n = 0; n < HIT_PAIRS; n++) begin
            send_word(make_word(FN_GET, 0, tracker.blk_tag[0], tracker.dev_tag[0],
                                1'b0, 1'b0));
            send_word(make_word(FN_RELEASE, 0, 16'h0000, 16'h0000, 1'b0, 1'b0));
        end

        idle_on = 1'b1;
        for (int n = 0; n < RANDOM_WORDS / 2; n++)
            send_word(random_word());

        wait_drained();
        repeat (40) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[sim.f]
rtl/bblru_pkg.sv
rtl/bblru_ram.sv
rtl/bblru_ctrl.sv
rtl/bblru_dp.sv
rtl/block_buffer_cache_lru_core.sv
sim/tb_top.sv
